### src/qmn_pkg.sv
package qmn_pkg;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_MUL  = 2'd1;
	localparam logic [1:0] OP_NORM = 2'd2;

	// bit (component*4 + term) set: that product enters the Hamilton sum negated
	localparam logic [15:0] NEG_TERMS = 16'h428E;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_MAC,
		ST_RND,
		ST_NCHK,
		ST_SQRW,
		ST_DSTART,
		ST_DIVW,
		ST_WB
	} state_t;

	typedef struct packed {
		logic start_sqrt;
		logic start_div;
	} sqdiv_ctl_t;

endpackage

### src/qmn_sqdiv.sv
module qmn_sqdiv #(
	parameter int FRAC_BITS = 30
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  qmn_pkg::sqdiv_ctl_t    ctl,
	input  logic [65:0]            rad,
	input  logic [31:0]            mag,
	output logic                   busy,
	output logic [FRAC_BITS:0]     quot
);

	localparam int QW = FRAC_BITS + 1;
	localparam int NW = 32 + FRAC_BITS;
	localparam logic [5:0] SQ_STEPS  = 6'd33;
	localparam logic [5:0] DIV_STEPS = 6'(QW);

	logic          busy_q;
	logic          div_mode_q;
	logic [5:0]    cnt_q;
	logic [65:0]   rad_q;
	logic [32:0]   root_q;
	logic [35:0]   rem_q;
	logic [QW-1:0] dnum_q;

	logic [35:0]   rem_sq;
	logic [35:0]   trial;
	logic          sq_ge;
	logic [35:0]   rem_dv;
	logic [35:0]   len_ext;
	logic          dv_ge;
	logic [NW-1:0] num;

	always_comb begin
		rem_sq  = {rem_q[33:0], rad_q[65:64]};
		trial   = {1'b0, root_q, 2'b01};
		sq_ge   = rem_sq >= trial;
		rem_dv  = {rem_q[34:0], dnum_q[QW-1]};
		len_ext = {3'd0, root_q};
		dv_ge   = rem_dv >= len_ext;
		num     = {mag, {FRAC_BITS{1'b0}}} + NW'(root_q >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			div_mode_q <= 1'b0;
			cnt_q      <= '0;
		end else if (ctl.start_sqrt) begin
			busy_q     <= 1'b1;
			div_mode_q <= 1'b0;
			cnt_q      <= SQ_STEPS;
		end else if (ctl.start_div) begin
			busy_q     <= 1'b1;
			div_mode_q <= 1'b1;
			cnt_q      <= DIV_STEPS;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start_sqrt) begin
			rad_q  <= rad;
			root_q <= '0;
			rem_q  <= '0;
		end else if (ctl.start_div) begin
			rem_q  <= 36'(num[NW-1:QW]);
			dnum_q <= num[QW-1:0];
		end else if (busy_q) begin
			if (!div_mode_q) begin
				rad_q <= {rad_q[63:0], 2'b00};
				if (sq_ge) begin
					rem_q  <= rem_sq - trial;
					root_q <= {root_q[31:0], 1'b1};
				end else begin
					rem_q  <= rem_sq;
					root_q <= {root_q[31:0], 1'b0};
				end
			end else begin
				dnum_q <= {dnum_q[QW-2:0], dv_ge};
				rem_q  <= dv_ge ? (rem_dv - len_ext) : rem_dv;
			end
		end
	end

	assign busy = busy_q;
	assign quot = dnum_q;

endmodule

### src/quaternion_multiply_normalize_unit_top.sv
// channel  | valid     | stall     | payload
// ---------+-----------+-----------+------------------------------------------------
// input    | in_valid  | in_stall  | op, operand_w, operand_x, operand_y, operand_z
// output   | out_valid | out_stall | result_w/x/y/z, zero_length, saturated
//
// One item at a time; in_stall is high from transfer until the result is registered.
// Multiply is paced by the single 32x32 multiplier (16 products, multiply then accumulate).
// Normalize is paced by the one-bit-per-cycle root and divide unit and skips that unit on
// zero length. Output stall holds the result register and, once the next result is
// ready, the sequencer. Reset gives identity.
module quaternion_multiply_normalize_unit_top #(
	parameter int FRAC_BITS = 30
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         op,
	input  logic signed [31:0] operand_w,
	input  logic signed [31:0] operand_x,
	input  logic signed [31:0] operand_y,
	input  logic signed [31:0] operand_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result_w,
	output logic signed [31:0] result_x,
	output logic signed [31:0] result_y,
	output logic signed [31:0] result_z,
	output logic               zero_length,
	output logic               saturated
);

	localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [65:0] RMAX = 66'sd2147483647;
	localparam logic signed [65:0] RMIN = -66'sd2147483648;
	localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;

	qmn_pkg::state_t       state_q, state_d;
	qmn_pkg::sqdiv_ctl_t   sd_ctl;

	logic [3:0]            cnt_q;
	logic signed [31:0]    acc_q [4];
	logic                  out_valid_q;
	logic                  zl_q;
	logic                  sat_q;

	logic [1:0]            op_q;
	logic signed [31:0]    opd_q [4];
	logic signed [31:0]    res_q [4];
	logic signed [63:0]    prod_q;
	logic signed [65:0]    sum_q;
	logic signed [31:0]    out_q [4];
	logic                  out_zl_q;
	logic                  out_sat_q;

	logic                  accept;
	logic                  out_free;
	logic signed [31:0]    mul_a;
	logic signed [31:0]    mul_b;
	logic signed [65:0]    prod_ext;
	logic signed [65:0]    rnd_sum;
	logic signed [65:0]    rnd_shift;
	logic signed [31:0]    rnd_val;
	logic                  rnd_sat;
	logic signed [31:0]    cur;
	logic [31:0]           mag;
	logic                  sd_busy;
	logic [FRAC_BITS:0]    quot;
	logic signed [31:0]    q_ext;
	logic signed [31:0]    div_val;

	qmn_sqdiv #(
		.FRAC_BITS(FRAC_BITS)
	) u_sqdiv (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (sd_ctl),
		.rad   (sum_q),
		.mag   (mag),
		.busy  (sd_busy),
		.quot  (quot)
	);

	always_comb begin
		accept   = in_valid && !in_stall;
		out_free = !out_valid_q || !out_stall;

		mul_a = acc_q[cnt_q[1:0]];
		mul_b = (op_q == qmn_pkg::OP_NORM) ? acc_q[cnt_q[1:0]]
			: opd_q[cnt_q[3:2] ^ cnt_q[1:0]];
		prod_ext = {{2{prod_q[63]}}, prod_q};

		rnd_sum   = sum_q + HALF;
		rnd_shift = rnd_sum >>> FRAC_BITS;
		rnd_sat   = 1'b0;
		if (rnd_shift > RMAX) begin
			rnd_val = 32'sh7FFFFFFF;
			rnd_sat = 1'b1;
		end else if (rnd_shift < RMIN) begin
			rnd_val = 32'sh80000000;
			rnd_sat = 1'b1;
		end else begin
			rnd_val = rnd_shift[31:0];
		end

		cur     = acc_q[cnt_q[1:0]];
		mag     = cur[31] ? 32'(-cur) : 32'(cur);
		q_ext   = 32'(quot);
		div_val = cur[31] ? -q_ext : q_ext;
	end

	always_comb begin
		state_d  = state_q;
		sd_ctl   = '0;
		in_stall = (state_q != qmn_pkg::ST_IDLE);
		case (state_q)
			qmn_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (op inside {qmn_pkg::OP_MUL, qmn_pkg::OP_NORM}) begin
						state_d = qmn_pkg::ST_MUL;
					end else begin
						state_d = qmn_pkg::ST_WB;
					end
				end
			end
			qmn_pkg::ST_MUL: begin
				state_d = qmn_pkg::ST_MAC;
			end
			qmn_pkg::ST_MAC: begin
				if (op_q == qmn_pkg::OP_NORM) begin
					state_d = (cnt_q == 4'd3) ? qmn_pkg::ST_NCHK : qmn_pkg::ST_MUL;
				end else begin
					state_d = (cnt_q[1:0] == 2'd3) ? qmn_pkg::ST_RND : qmn_pkg::ST_MUL;
				end
			end
			qmn_pkg::ST_RND: begin
				state_d = (cnt_q == 4'd15) ? qmn_pkg::ST_WB : qmn_pkg::ST_MUL;
			end
			qmn_pkg::ST_NCHK: begin
				if (sum_q == '0) begin
					state_d = qmn_pkg::ST_WB;
				end else begin
					sd_ctl.start_sqrt = 1'b1;
					state_d = qmn_pkg::ST_SQRW;
				end
			end
			qmn_pkg::ST_SQRW: begin
				if (!sd_busy) begin
					state_d = qmn_pkg::ST_DSTART;
				end
			end
			qmn_pkg::ST_DSTART: begin
				sd_ctl.start_div = 1'b1;
				state_d = qmn_pkg::ST_DIVW;
			end
			qmn_pkg::ST_DIVW: begin
				if (!sd_busy) begin
					state_d = (cnt_q[1:0] == 2'd3) ? qmn_pkg::ST_WB : qmn_pkg::ST_DSTART;
				end
			end
			qmn_pkg::ST_WB: begin
				if (out_free) begin
					state_d = qmn_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = qmn_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qmn_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			acc_q[0]    <= ONE;
			acc_q[1]    <= '0;
			acc_q[2]    <= '0;
			acc_q[3]    <= '0;
			out_valid_q <= 1'b0;
			zl_q        <= 1'b0;
			sat_q       <= 1'b0;
		end else begin
			if (state_q == qmn_pkg::ST_WB && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				qmn_pkg::ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						zl_q  <= 1'b0;
						sat_q <= 1'b0;
					end
				end
				qmn_pkg::ST_MAC: begin
					if (state_d == qmn_pkg::ST_MUL) begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				qmn_pkg::ST_RND: begin
					cnt_q <= cnt_q + 4'd1;
					if (rnd_sat) begin
						sat_q <= 1'b1;
					end
				end
				qmn_pkg::ST_NCHK: begin
					cnt_q <= '0;
					if (sum_q == '0) begin
						zl_q <= 1'b1;
					end
				end
				qmn_pkg::ST_DIVW: begin
					if (!sd_busy) begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				qmn_pkg::ST_WB: begin
					if (out_free) begin
						acc_q <= res_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			qmn_pkg::ST_IDLE: begin
				if (accept) begin
					op_q     <= op;
					opd_q[0] <= operand_w;
					opd_q[1] <= operand_x;
					opd_q[2] <= operand_y;
					opd_q[3] <= operand_z;
					sum_q    <= '0;
					if (op == qmn_pkg::OP_LOAD) begin
						res_q[0] <= operand_w;
						res_q[1] <= operand_x;
						res_q[2] <= operand_y;
						res_q[3] <= operand_z;
					end else begin
						res_q <= acc_q;
					end
				end
			end
			qmn_pkg::ST_MUL: begin
				prod_q <= mul_a * mul_b;
			end
			qmn_pkg::ST_MAC: begin
				if (op_q != qmn_pkg::OP_NORM && qmn_pkg::NEG_TERMS[cnt_q]) begin
					sum_q <= sum_q - prod_ext;
				end else begin
					sum_q <= sum_q + prod_ext;
				end
			end
			qmn_pkg::ST_RND: begin
				res_q[cnt_q[3:2]] <= rnd_val;
				sum_q             <= '0;
			end
			qmn_pkg::ST_DIVW: begin
				if (!sd_busy) begin
					res_q[cnt_q[1:0]] <= div_val;
				end
			end
			qmn_pkg::ST_WB: begin
				if (out_free) begin
					out_q     <= res_q;
					out_zl_q  <= zl_q;
					out_sat_q <= sat_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign result_w    = out_q[0];
	assign result_x    = out_q[1];
	assign result_y    = out_q[2];
	assign result_z    = out_q[3];
	assign zero_length = out_zl_q;
	assign saturated   = out_sat_q;

	a_accept_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input transfer not followed by stall");

	a_unit_owner: assert property (@(posedge clk) disable iff (!arst_n)
		sd_busy |-> (state_q == qmn_pkg::ST_SQRW || state_q == qmn_pkg::ST_DIVW))
		else $error("root/divide unit busy outside its wait states");

	a_flag_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(zero_length && saturated))
		else $error("zero length and saturation flagged together");

	a_norm_squares: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == qmn_pkg::ST_MUL && op_q == qmn_pkg::OP_NORM) |-> (cnt_q[3:2] == 2'd0))
		else $error("normalize square index out of range");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int FRAC = 30;
	localparam logic [1:0] OP_NONE = 2'd3;
	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] Q_ONE = 32'sh4000_0000;
	localparam logic signed [67:0] HALF_LSB = 68'sd1 <<< (FRAC - 1);
	localparam logic signed [67:0] LIM_HI = 68'sd2147483647;
	localparam logic signed [67:0] LIM_LO = -68'sd2147483648;
	localparam int DRAIN_CYCLES = 250;

	typedef struct packed {
		logic signed [31:0] w;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               zero_length;
		logic               saturated;
	} attitude_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         op;
	logic signed [31:0] operand_w;
	logic signed [31:0] operand_x;
	logic signed [31:0] operand_y;
	logic signed [31:0] operand_z;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] result_w;
	logic signed [31:0] result_x;
	logic signed [31:0] result_y;
	logic signed [31:0] result_z;
	logic               zero_length;
	logic               saturated;

	logic signed [31:0] att_q [4];
	attitude_t          pending_attitudes [$];
	int                 mismatches = 0;
	int                 src_idle_pct = 0;
	int                 sink_stall_pct = 0;

	quaternion_multiply_normalize_unit_top #(
		.FRAC_BITS(FRAC)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.operand_w  (operand_w),
		.operand_x  (operand_x),
		.operand_y  (operand_y),
		.operand_z  (operand_z),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result_w   (result_w),
		.result_x   (result_x),
		.result_y   (result_y),
		.result_z   (result_z),
		.zero_length(zero_length),
		.saturated  (saturated)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < sink_stall_pct);
	end

	function automatic logic [32:0] round_clamp(input logic signed [67:0] sum);
		logic signed [67:0] t;
		t = (sum + HALF_LSB) >>> FRAC;
		if (t > LIM_HI)
			return {1'b1, Q_MAX};
		if (t < LIM_LO)
			return {1'b1, Q_MIN};
		return {1'b0, t[31:0]};
	endfunction

	function automatic logic [63:0] isqrt(input logic [67:0] n);
		logic [33:0] r;
		logic [33:0] t;
		logic [67:0] sq;
		int          i;
		r = '0;
		for (i = 33; i >= 0; i--) begin
			t = r | (34'd1 << i);
			sq = 68'(t) * 68'(t);
			if (sq <= n)
				r = t;
		end
		return 64'(r);
	endfunction

	function automatic logic [32:0] scale_by_length(input logic signed [31:0] c,
			input logic [63:0] len);
		logic [63:0] m;
		logic [63:0] q;
		m = (c < 0) ? 64'(-64'(c)) : 64'(c);
		q = ((m << FRAC) + (len >> 1)) / len;
		if (q > 64'h8000_0000)
			q = 64'h8000_0000;
		if (c < 0)
			return {1'b0, 32'(-q)};
		if (q > 64'h7FFF_FFFF)
			return {1'b1, Q_MAX};
		return {1'b0, q[31:0]};
	endfunction

	function automatic attitude_t next_attitude(input logic [1:0] code,
			input logic signed [31:0] bw, input logic signed [31:0] bx,
			input logic signed [31:0] by, input logic signed [31:0] bz);
		attitude_t          r;
		logic signed [67:0] a [4];
		logic signed [67:0] b [4];
		logic signed [67:0] s;
		logic [32:0]        c [4];
		logic [63:0]        len;
		int                 i;
		r.zero_length = 1'b0;
		r.saturated = 1'b0;
		for (i = 0; i < 4; i++)
			a[i] = att_q[i];
		b[0] = bw;
		b[1] = bx;
		b[2] = by;
		b[3] = bz;
		case (code)
			qmn_pkg::OP_LOAD: begin
				att_q[0] = bw;
				att_q[1] = bx;
				att_q[2] = by;
				att_q[3] = bz;
			end
			qmn_pkg::OP_MUL: begin
				c[0] = round_clamp(a[0] * b[0] - a[1] * b[1] - a[2] * b[2] - a[3] * b[3]);
				c[1] = round_clamp(a[0] * b[1] + a[1] * b[0] + a[2] * b[3] - a[3] * b[2]);
				c[2] = round_clamp(a[0] * b[2] - a[1] * b[3] + a[2] * b[0] + a[3] * b[1]);
				c[3] = round_clamp(a[0] * b[3] + a[1] * b[2] - a[2] * b[1] + a[3] * b[0]);
				for (i = 0; i < 4; i++) begin
					att_q[i] = c[i][31:0];
					r.saturated = r.saturated | c[i][32];
				end
			end
			qmn_pkg::OP_NORM: begin
				s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3];
				if (s == 0) begin
					r.zero_length = 1'b1;
				end else begin
					len = isqrt(s);
					for (i = 0; i < 4; i++) begin
						c[i] = scale_by_length(att_q[i], len);
						att_q[i] = c[i][31:0];
						r.saturated = r.saturated | c[i][32];
					end
				end
			end
			default: begin
			end
		endcase
		r.w = att_q[0];
		r.x = att_q[1];
		r.y = att_q[2];
		r.z = att_q[3];
		return r;
	endfunction

	function automatic logic signed [31:0] rand_component();
		case ($urandom_range(9))
			0: return Q_MIN;
			1: return Q_MAX;
			2: return 32'sd0;
			3, 4: return $signed($urandom);
			5: return $signed(32'($urandom_range(16))) - 32'sd8;
			default: return $signed($urandom_range(32'h7FFF_FFFF)) - Q_ONE;
		endcase
	endfunction

	task automatic send_item(input logic [1:0] code, input logic signed [31:0] w,
			input logic signed [31:0] x, input logic signed [31:0] y,
			input logic signed [31:0] z);
		if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		in_valid <= 1'b1;
		op <= code;
		operand_w <= w;
		operand_x <= x;
		operand_y <= y;
		operand_z <= z;
		do @(posedge clk); while (in_stall);
		pending_attitudes.push_back(next_attitude(code, w, x, y, z));
	endtask

	task automatic send_random(input logic [1:0] code);
		send_item(code, rand_component(), rand_component(), rand_component(),
			rand_component());
	endtask

	task automatic pause_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_attitudes.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : check_results
		attitude_t want;
		if (out_valid && !out_stall) begin
			if (pending_attitudes.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %h %h %h %h %b %b",
					$time, result_w, result_x, result_y, result_z, zero_length, saturated);
				mismatches++;
			end else begin
				want = pending_attitudes.pop_front();
				check_field("result_w", want.w, result_w);
				check_field("result_x", want.x, result_x);
				check_field("result_y", want.y, result_y);
				check_field("result_z", want.z, result_z);
				check_field("zero_length", 32'(want.zero_length), 32'(zero_length));
				check_field("saturated", 32'(want.saturated), 32'(saturated));
			end
		end
	end

	task automatic test_reset_identity();
		send_random(OP_NONE);
		send_item(qmn_pkg::OP_NORM, Q_MIN, Q_MAX, 32'sd0, -32'sd1);
	endtask

	task automatic test_load_extremes();
		send_item(qmn_pkg::OP_LOAD, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
		send_item(OP_NONE, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
		send_item(qmn_pkg::OP_LOAD, Q_MIN, Q_MAX, 32'sd0, -32'sd1);
	endtask

	task automatic test_multiply_corners();
		send_item(qmn_pkg::OP_LOAD, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
		send_item(qmn_pkg::OP_MUL, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
		send_item(qmn_pkg::OP_LOAD, Q_MIN, 32'sd0, 32'sd0, 32'sd0);
		send_item(qmn_pkg::OP_MUL, Q_MIN, 32'sd0, 32'sd0, 32'sd0);
		send_item(qmn_pkg::OP_LOAD, 32'sd0, Q_ONE, 32'sd0, 32'sd0);
		send_item(qmn_pkg::OP_MUL, 32'sd0, 32'sd0, Q_ONE, 32'sd0);
		send_item(qmn_pkg::OP_MUL, Q_ONE, 32'sd0, 32'sd0, 32'sd0);
		// ties: +half rounds up, -half rounds to zero
		send_item(qmn_pkg::OP_LOAD, 32'sd32768, 32'sd0, 32'sd0, 32'sd0);
		send_item(qmn_pkg::OP_MUL, 32'sd16384, -32'sd16384, 32'sd0, 32'sd0);
	endtask

	task automatic test_normalize_corners();
		send_item(qmn_pkg::OP_LOAD, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
		send_random(qmn_pkg::OP_NORM);
		send_item(qmn_pkg::OP_LOAD, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
		send_random(qmn_pkg::OP_NORM);
		send_item(qmn_pkg::OP_LOAD, 32'sd3, -32'sd4, 32'sd0, 32'sd0);
		send_random(qmn_pkg::OP_NORM);
		send_item(qmn_pkg::OP_LOAD, Q_MAX, 32'sd0, 32'sd0, -32'sd1);
		send_random(qmn_pkg::OP_NORM);
	endtask

	task automatic test_random_mix(input int n_items, input int src_pct, input int sink_pct);
		int k;
		int pick;
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		for (k = 0; k < n_items; k++) begin
			pick = $urandom_range(99);
			if (pick < 5) begin
				send_item(qmn_pkg::OP_LOAD, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
				send_random(qmn_pkg::OP_NORM);
			end else if (pick < 8) begin
				send_item(qmn_pkg::OP_LOAD, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
				send_random(qmn_pkg::OP_NORM);
			end else if (pick < 28) begin
				send_random(qmn_pkg::OP_LOAD);
			end else if (pick < 60) begin
				send_random(qmn_pkg::OP_MUL);
			end else if (pick < 90) begin
				send_random(qmn_pkg::OP_NORM);
			end else begin
				send_random(OP_NONE);
			end
		end
		src_idle_pct = 0;
		sink_stall_pct = 0;
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		op <= qmn_pkg::OP_LOAD;
		operand_w <= '0;
		operand_x <= '0;
		operand_y <= '0;
		operand_z <= '0;
		att_q[0] = Q_ONE;
		att_q[1] = '0;
		att_q[2] = '0;
		att_q[3] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_identity();
		test_load_extremes();
		test_multiply_corners();
		test_normalize_corners();
		pause_until_drained();
		test_random_mix(155, 0, 0);
		pause_until_drained();
		test_random_mix(155, 55, 0);
		pause_until_drained();
		test_random_mix(155, 0, 55);
		pause_until_drained();
		test_random_mix(155, 26, 26);
		pause_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
